// ===== rtl/tmx_pkg.sv =====
// Shared constants and command codes for the tape machine execute unit.
// No dependencies; used by the channel interfaces and the top level.
package tmx_pkg;

  // Width of one program character or data byte
  localparam int BYTE_W     = 8;

  // Tape geometry
  localparam int TAPE_DEPTH = 16384;
  localparam int PTR_W      = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;

  // Cell arithmetic is modulo 2^16 + 1
  localparam int CELL_W     = 17;
  localparam int LO_W       = 16;
  localparam int CELL_MOD   = 65537;

  // Command characters
  typedef enum logic [BYTE_W-1:0] {
    OP_HALT  = 8'h00,  // NUL
    OP_NOP   = 8'h23,  // '#'
    OP_INC   = 8'h2B,  // '+'
    OP_IN    = 8'h2C,  // ','
    OP_DEC   = 8'h2D,  // '-'
    OP_OUT   = 8'h2E,  // '.'
    OP_LEFT  = 8'h3C,  // '<'
    OP_EQ    = 8'h3D,  // '='
    OP_RIGHT = 8'h3E,  // '>'
    OP_BRZ   = 8'h5B,  // '['
    OP_BRNZ  = 8'h5D,  // ']'
    OP_ADD   = 8'h61,  // 'a'
    OP_LOAD  = 8'h6C,  // 'l'
    OP_MUL   = 8'h6D,  // 'm'
    OP_STORE = 8'h73,  // 's'
    OP_CLEAR = 8'h7A   // 'z'
  } opcode_e;

endpackage

// ===== rtl/tmx_cmd_if.sv =====
// Command channel: one program character and an input byte per beat.
// Depends on tmx_pkg for the byte width.
interface tmx_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [tmx_pkg::BYTE_W-1:0] cmd;
  logic [tmx_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

// ===== rtl/tmx_res_if.sv =====
// Result channel: output byte and status flags, one beat per command.
// Depends on tmx_pkg for the byte width.
interface tmx_res_if;
  logic                       valid;
  logic                       ready;
  logic                       out_valid;
  logic [tmx_pkg::BYTE_W-1:0] out_byte;
  logic                       branch_taken;
  logic                       halted;
  logic                       bad_opcode;

  modport source (output valid, output out_valid, output out_byte, output branch_taken,
                  output halted, output bad_opcode, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input branch_taken,
                  input halted, input bad_opcode, output ready);
endinterface

// ===== rtl/tape_machine_execute_unit.sv =====
// Execute stage of the tape machine: tape memory, pointer, hold register.
// Depends on tmx_pkg, tmx_cmd_if and tmx_res_if.

// The unit retires one command per clock cycle when the result side keeps
// up; each command passes the execute stage, then the result register.
// The rate is set by the read-modify-write of the tape memory: both
// cells a command needs are read at the beat, and the execute cycle writes
// the current cell back, with a bypass from the last write covering a
// command that reads a cell its predecessor has just written. After reset
// the tape is swept to zero, one cell a cycle, over all TAPE_DEPTH (16384)
// cells, during which ready stays low. Bracket matching and fetch are not
// done here: '[' and ']' only report whether the branch is taken.
module tape_machine_execute_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  tmx_cmd_if.sink  cmd_i,
  tmx_res_if.source res_o
);

  localparam int PW = tmx_pkg::PTR_W;
  localparam int CW = tmx_pkg::CELL_W;
  localparam int LW = tmx_pkg::LO_W;
  localparam int BW = tmx_pkg::BYTE_W;

  localparam logic [PW-1:0] LastIdx  = PW'(tmx_pkg::TAPE_DEPTH - 1);
  localparam logic [CW:0]   ModW     = (CW+1)'(tmx_pkg::CELL_MOD);
  localparam logic [CW-1:0] CellMax  = CW'(tmx_pkg::CELL_MOD - 1);

  // Tape memory
  logic [CW-1:0] tape_mem [tmx_pkg::TAPE_DEPTH];

  // Control state
  logic          clr_busy_q, clr_busy_d;
  logic [PW-1:0] clr_cnt_q, clr_cnt_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] hold_q, hold_d;
  logic          s1_valid_q, s1_valid_d;
  logic          res_valid_q, res_valid_d;
  logic          fwd_valid_q, fwd_valid_d;

  // Execute stage payload
  logic [BW-1:0] s1_cmd_q;
  logic [BW-1:0] s1_byte_q;
  logic [PW-1:0] s1_ptr_q;
  logic [PW-1:0] s1_nptr_q;
  logic [CW-1:0] rd_cur_q, rd_nxt_q;

  // Last write, for the bypass
  logic [PW-1:0] fwd_addr_q;
  logic [CW-1:0] fwd_data_q;

  // Result register payload
  logic          res_out_valid_q;
  logic [BW-1:0] res_out_byte_q;
  logic          res_branch_q;
  logic          res_halted_q;
  logic          res_bad_q;

  // Handshake
  logic out_free, s1_adv, cmd_acc;
  logic [PW-1:0] nptr;

  // Execute results
  logic          ex_wr;
  logic [CW-1:0] ex_wdata;
  logic          ex_hold_we;
  logic          ex_out_valid;
  logic [BW-1:0] ex_out_byte;
  logic          ex_branch;
  logic          ex_halted;
  logic          ex_bad;
  logic [CW-1:0] cur, nxt;
  logic [CW:0]   sum;
  logic [2*CW-1:0] prod;
  logic [CW-1:0] prod_hi;
  logic [CW:0]   mul_lo, mul_adj;

  // Memory write port
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;

  // Handshake and pipeline advance
  assign out_free    = !res_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign cmd_i.ready = !clr_busy_q && (!s1_valid_q || out_free);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign nptr        = (ptr_q == LastIdx) ? '0 : ptr_q + PW'(1);

  // Pointer moves are resolved at the beat, ahead of the data
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_acc) begin
      unique case (cmd_i.cmd)
        tmx_pkg::OP_RIGHT: ptr_d = nptr;
        tmx_pkg::OP_LEFT:  ptr_d = (ptr_q == '0) ? LastIdx : ptr_q - PW'(1);
        default:           ptr_d = ptr_q;
      endcase
    end
  end

  // Operands, with bypass from the write made at the read edge
  assign cur = (fwd_valid_q && fwd_addr_q == s1_ptr_q)  ? fwd_data_q : rd_cur_q;
  assign nxt = (fwd_valid_q && fwd_addr_q == s1_nptr_q) ? fwd_data_q : rd_nxt_q;

  // Mod 65537 add and multiply; 2^16 is -1, so high half subtracts
  assign sum     = {1'b0, cur} + {1'b0, nxt};
  assign prod    = {{CW{1'b0}}, cur} * {{CW{1'b0}}, nxt};
  assign prod_hi = prod[LW+CW-1:LW];
  assign mul_lo  = (CW+1)'(prod[LW-1:0]);
  assign mul_adj = mul_lo + ModW - {1'b0, prod_hi};

  // Command execution
  always_comb begin
    ex_wr        = 1'b0;
    ex_wdata     = cur;
    ex_hold_we   = 1'b0;
    ex_out_valid = 1'b0;
    ex_out_byte  = '0;
    ex_branch    = 1'b0;
    ex_halted    = 1'b0;
    ex_bad       = 1'b0;
    unique case (s1_cmd_q)
      tmx_pkg::OP_INC: begin
        ex_wr    = 1'b1;
        ex_wdata = (cur == CellMax) ? '0 : cur + CW'(1);
      end
      tmx_pkg::OP_DEC: begin
        ex_wr    = 1'b1;
        ex_wdata = (cur == '0) ? CellMax : cur - CW'(1);
      end
      tmx_pkg::OP_RIGHT, tmx_pkg::OP_LEFT, tmx_pkg::OP_NOP: ;
      tmx_pkg::OP_BRZ:  ex_branch = (cur == '0);
      tmx_pkg::OP_BRNZ: ex_branch = (cur != '0);
      tmx_pkg::OP_EQ: begin
        ex_wr    = 1'b1;
        ex_wdata = (cur == nxt) ? CW'(1) : '0;
      end
      tmx_pkg::OP_IN: begin
        ex_wr    = 1'b1;
        ex_wdata = CW'(s1_byte_q);
      end
      tmx_pkg::OP_OUT: begin
        ex_out_valid = 1'b1;
        ex_out_byte  = cur[BW-1:0];
      end
      tmx_pkg::OP_HALT: ex_halted = 1'b1;
      tmx_pkg::OP_LOAD: ex_hold_we = 1'b1;
      tmx_pkg::OP_STORE: begin
        ex_wr    = 1'b1;
        ex_wdata = hold_q;
      end
      tmx_pkg::OP_CLEAR: begin
        ex_wr    = 1'b1;
        ex_wdata = '0;
      end
      tmx_pkg::OP_ADD: begin
        ex_wr    = 1'b1;
        ex_wdata = (sum >= ModW) ? CW'(sum - ModW) : CW'(sum);
      end
      tmx_pkg::OP_MUL: begin
        ex_wr    = 1'b1;
        ex_wdata = (mul_adj >= ModW) ? CW'(mul_adj - ModW) : CW'(mul_adj);
      end
      default: ex_bad = 1'b1;
    endcase
  end

  // Memory write select: clearing sweep or execute write-back
  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv && ex_wr;
      mem_waddr = s1_ptr_q;
      mem_wdata = ex_wdata;
    end
  end

  // Next state of control registers
  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_cnt_d   = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + PW'(1);
      if (clr_cnt_q == LastIdx) begin
        clr_busy_d = 1'b0;
      end
    end
    hold_d      = (s1_adv && ex_hold_we) ? cur : hold_q;
    s1_valid_d  = cmd_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    res_valid_d = s1_adv ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);
    fwd_valid_d = (!clr_busy_q && mem_we) ? 1'b1 : fwd_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      ptr_q       <= '0;
      hold_q      <= '0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
      ptr_q       <= ptr_d;
      hold_q      <= hold_d;
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  // Tape memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tape_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_acc) begin
      rd_cur_q <= tape_mem[ptr_q];
      rd_nxt_q <= tape_mem[nptr];
    end
  end

  // Execute stage payload, loaded at the beat
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      s1_cmd_q  <= cmd_i.cmd;
      s1_byte_q <= cmd_i.in_byte;
      s1_ptr_q  <= ptr_q;
      s1_nptr_q <= nptr;
    end
  end

  // Bypass register tracks the latest execute write
  always_ff @(posedge clk_i) begin
    if (!clr_busy_q && mem_we) begin
      fwd_addr_q <= mem_waddr;
      fwd_data_q <= mem_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_out_valid_q <= ex_out_valid;
      res_out_byte_q  <= ex_out_byte;
      res_branch_q    <= ex_branch;
      res_halted_q    <= ex_halted;
      res_bad_q       <= ex_bad;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.out_valid    = res_out_valid_q;
  assign res_o.out_byte     = res_out_byte_q;
  assign res_o.branch_taken = res_branch_q;
  assign res_o.halted       = res_halted_q;
  assign res_o.bad_opcode   = res_bad_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tape_machine_execute_unit: directed and random commands.
// Depends on tmx_pkg, tmx_cmd_if, tmx_res_if and the execute unit RTL.

module tb_top;

  localparam int BYTE_W     = tmx_pkg::BYTE_W;
  localparam int CELL_W     = tmx_pkg::CELL_W;
  localparam int PTR_W      = tmx_pkg::PTR_W;
  localparam int TAPE_DEPTH = tmx_pkg::TAPE_DEPTH;
  localparam int CELL_MOD   = tmx_pkg::CELL_MOD;

  // Reset sweep covers all TAPE_DEPTH cells, so the limit leaves ample headroom on top.
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] in_byte;
  } cmd_item_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              branch_taken;
    logic              halted;
    logic              bad_opcode;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tmx_cmd_if cmd_if ();
  tmx_res_if res_if ();

  tape_machine_execute_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Predicted machine state
  logic [CELL_W-1:0] model_tape [TAPE_DEPTH];
  logic [PTR_W-1:0]  model_ptr;
  logic [CELL_W-1:0] model_hold;

  cmd_item_t   program_q [$];
  status_t     status_q [$];
  cmd_item_t   next_item;
  bit          cmd_beat = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Executes one command on the predicted state and returns its status beat
  function automatic status_t execute_cmd(cmd_item_t it);
    logic [PTR_W-1:0]  nxt_ptr;
    logic [CELL_W-1:0] cur;
    logic [CELL_W-1:0] nxt;
    status_t           st;
    nxt_ptr = (model_ptr == PTR_W'(TAPE_DEPTH - 1)) ? '0 : model_ptr + PTR_W'(1);
    cur     = model_tape[model_ptr];
    nxt     = model_tape[nxt_ptr];
    st      = '0;
    case (it.cmd)
      tmx_pkg::OP_INC:
        model_tape[model_ptr] = (cur == CELL_W'(CELL_MOD - 1)) ? '0 : cur + CELL_W'(1);
      tmx_pkg::OP_DEC:
        model_tape[model_ptr] = (cur == '0) ? CELL_W'(CELL_MOD - 1) : cur - CELL_W'(1);
      tmx_pkg::OP_RIGHT: model_ptr = nxt_ptr;
      tmx_pkg::OP_LEFT:
        model_ptr = (model_ptr == '0) ? PTR_W'(TAPE_DEPTH - 1) : model_ptr - PTR_W'(1);
      tmx_pkg::OP_BRZ:   st.branch_taken = (cur == '0);
      tmx_pkg::OP_BRNZ:  st.branch_taken = (cur != '0);
      tmx_pkg::OP_EQ:    model_tape[model_ptr] = (cur == nxt) ? CELL_W'(1) : '0;
      tmx_pkg::OP_IN:    model_tape[model_ptr] = CELL_W'(it.in_byte);
      tmx_pkg::OP_OUT: begin
        st.out_valid = 1'b1;
        st.out_byte  = cur[BYTE_W-1:0];
      end
      tmx_pkg::OP_HALT:  st.halted = 1'b1;
      tmx_pkg::OP_LOAD:  model_hold = cur;
      tmx_pkg::OP_STORE: model_tape[model_ptr] = model_hold;
      tmx_pkg::OP_CLEAR: model_tape[model_ptr] = '0;
      tmx_pkg::OP_ADD:
        model_tape[model_ptr] = CELL_W'((32'(cur) + 32'(nxt)) % CELL_MOD);
      tmx_pkg::OP_MUL:
        model_tape[model_ptr] = CELL_W'((64'(cur) * 64'(nxt)) % CELL_MOD);
      tmx_pkg::OP_NOP:   ;
      default:           st.bad_opcode = 1'b1;
    endcase
    return st;
  endfunction

  function automatic void queue_item(logic [BYTE_W-1:0] cmd, logic [BYTE_W-1:0] in_byte);
    cmd_item_t it;
    it.cmd     = cmd;
    it.in_byte = in_byte;
    program_q.push_back(it);
    queued_cnt++;
  endfunction

  // Mostly valid commands with random data; a little noise and stray halts
  function automatic void queue_random_item();
    int unsigned r;
    logic [BYTE_W-1:0] c;
    r = $urandom_range(99);
    if (r < 6) begin
      c = BYTE_W'($urandom_range(255));
    end else if (r < 8) begin
      c = tmx_pkg::OP_HALT;
    end else begin
      case ($urandom_range(14))
        0:       c = tmx_pkg::OP_INC;
        1:       c = tmx_pkg::OP_DEC;
        2:       c = tmx_pkg::OP_RIGHT;
        3:       c = tmx_pkg::OP_LEFT;
        4:       c = tmx_pkg::OP_BRZ;
        5:       c = tmx_pkg::OP_BRNZ;
        6:       c = tmx_pkg::OP_EQ;
        7:       c = tmx_pkg::OP_IN;
        8:       c = tmx_pkg::OP_OUT;
        9:       c = tmx_pkg::OP_LOAD;
        10:      c = tmx_pkg::OP_STORE;
        11:      c = tmx_pkg::OP_CLEAR;
        12:      c = tmx_pkg::OP_ADD;
        13:      c = tmx_pkg::OP_MUL;
        default: c = tmx_pkg::OP_NOP;
      endcase
    end
    queue_item(c, BYTE_W'($urandom_range(255)));
  endfunction

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n_items);
    int unsigned i;
    @(posedge clk_i);
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    for (i = 0; i < n_items; i++) queue_random_item();
    // sender holds off until every outstanding status beat is back
    do @(negedge clk_i); while (accepted_cnt != queued_cnt || status_q.size() != 0);
  endtask

  // Command driver and result-side back-pressure, both at the falling edge
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    if (!cmd_if.valid || cmd_beat) begin
      if (program_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_item = program_q.pop_front();
        cmd_if.valid   <= 1'b1;
        cmd_if.cmd     <= next_item.cmd;
        cmd_if.in_byte <= next_item.in_byte;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on each command beat, check each status beat
  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    cycle_cnt++;
    cmd_beat = rst_ni && cmd_if.valid && cmd_if.ready;
    if (cmd_beat) begin
      status_q.push_back(execute_cmd({cmd_if.cmd, cmd_if.in_byte}));
      accepted_cnt++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.out_valid, res_if.out_byte, res_if.branch_taken,
             res_if.halted, res_if.bad_opcode};
      if (status_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("[%0t] status beat with none expected: ov=%b ob=%h br=%b h=%b bad=%b",
                   $realtime, got.out_valid, got.out_byte, got.branch_taken,
                   got.halted, got.bad_opcode);
      end else begin
        want = status_q.pop_front();
        if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
            got.branch_taken !== want.branch_taken || got.halted !== want.halted ||
            got.bad_opcode !== want.bad_opcode) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch: exp ov=%b ob=%h br=%b h=%b bad=%b, got ov=%b ob=%h br=%b h=%b bad=%b",
                     $realtime, want.out_valid, want.out_byte, want.branch_taken,
                     want.halted, want.bad_opcode, got.out_valid, got.out_byte,
                     got.branch_taken, got.halted, got.bad_opcode);
        end
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Reset, directed commands, then four random phases with different idling and stalling
  initial begin
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.cmd     = '0;
    cmd_if.in_byte = '0;
    res_if.ready   = 1'b0;
    foreach (model_tape[i]) model_tape[i] = '0;
    model_ptr  = '0;
    model_hold = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    @(posedge clk_i);
    queue_item(tmx_pkg::OP_OUT,   8'h00);  // output of a cleared cell
    queue_item(tmx_pkg::OP_DEC,   8'h00);  // zero decrements to the top residue
    queue_item(tmx_pkg::OP_OUT,   8'h00);  // top residue has low byte zero
    queue_item(tmx_pkg::OP_BRNZ,  8'hFF);  // taken on nonzero
    queue_item(tmx_pkg::OP_INC,   8'h00);  // top residue increments back to zero
    queue_item(tmx_pkg::OP_BRZ,   8'h00);  // taken on zero
    queue_item(tmx_pkg::OP_BRNZ,  8'h00);  // not taken on zero
    queue_item(tmx_pkg::OP_LEFT,  8'h00);  // pointer wraps down to the last cell
    queue_item(tmx_pkg::OP_DEC,   8'h00);
    queue_item(tmx_pkg::OP_LOAD,  8'h00);
    queue_item(tmx_pkg::OP_RIGHT, 8'h00);  // pointer wraps up to cell zero
    queue_item(tmx_pkg::OP_STORE, 8'h00);
    queue_item(tmx_pkg::OP_LEFT,  8'h00);
    queue_item(tmx_pkg::OP_MUL,   8'h00);  // next cell wraps to cell zero; (-1)*(-1) = 1
    queue_item(tmx_pkg::OP_ADD,   8'h00);  // 1 + top residue wraps to zero
    queue_item(tmx_pkg::OP_EQ,    8'h00);  // unequal neighbours
    queue_item(tmx_pkg::OP_RIGHT, 8'h00);
    queue_item(tmx_pkg::OP_CLEAR, 8'h00);
    queue_item(tmx_pkg::OP_LEFT,  8'h00);
    queue_item(tmx_pkg::OP_EQ,    8'h00);  // equal neighbours
    queue_item(tmx_pkg::OP_IN,    8'hFF);
    queue_item(tmx_pkg::OP_OUT,   8'h5A);
    queue_item(tmx_pkg::OP_NOP,   8'hAA);
    queue_item(tmx_pkg::OP_HALT,  8'h55);  // halt leaves state alone and is not sticky
    queue_item(8'hFF,             8'h00);  // unknown character
    queue_item(8'h41,             8'hFF);

    run_phase(0,  0,  400);
    run_phase(78, 0,  410);
    run_phase(0,  78, 410);
    run_phase(20, 20, 410);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== tape_machine_execute_unit.f =====
rtl/tmx_pkg.sv
rtl/tmx_cmd_if.sv
rtl/tmx_res_if.sv
rtl/tape_machine_execute_unit.sv
tb/tb_top.sv
